### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked property, skipped while reset is high
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Checked property, also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/core/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg
// Types, codes and constant tables of the vending change controller.
// ----------------------------------------------------------------------------
`default_nettype none

package vcc_pkg;

  localparam int NumProducts = 4;
  localparam int NumDenoms   = 8;
  localparam int NumPrices   = 4;

  localparam int CntW    = 8;    // stock / coin counts
  localparam int PriceW  = 12;
  localparam int MoneyW  = 10;
  localparam int BalW    = 16;
  localparam int ProdW   = 18;   // count times coin value
  localparam int ShiftW  = 4;    // divider bit position, 0..CntW

  // Commands
  localparam logic [2:0] CMD_INSERT     = 3'd0;
  localparam logic [2:0] CMD_SELECT     = 3'd1;
  localparam logic [2:0] CMD_CHANGE     = 3'd2;
  localparam logic [2:0] CMD_LOAD_STOCK = 3'd3;
  localparam logic [2:0] CMD_LOAD_COINS = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_ACCEPTED    = 3'd0;
  localparam logic [2:0] ST_REJECTED    = 3'd1;
  localparam logic [2:0] ST_VENDED      = 3'd2;
  localparam logic [2:0] ST_NO_STOCK    = 3'd3;
  localparam logic [2:0] ST_SHORT_FUNDS = 3'd4;
  localparam logic [2:0] ST_COINS_OUT   = 3'd5;
  localparam logic [2:0] ST_CHANGE_DONE = 3'd6;
  localparam logic [2:0] ST_LOADED      = 3'd7;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [MoneyW-1:0] money_value;
    logic [1:0]        product_index;
    logic [2:0]        denom_index;
    logic [CntW-1:0]   load_count;
  } vcc_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        product_out;
    logic [MoneyW-1:0] denomination;
    logic [CntW-1:0]   coin_count;
    logic [BalW-1:0]   balance_now;
    logic [BalW-1:0]   remaining_change;
    logic              last;
  } vcc_out_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic            busy;
    logic            done;
    logic [CntW-1:0] quot;   // saturated at all ones
  } vcc_div_st_t;

  // Coin value of each slot, slot 0 largest
  function automatic logic [MoneyW-1:0] denom_val(input logic [2:0] slot);
    logic [MoneyW-1:0] v;
    case (slot)
      3'd0:    v = 10'd1000;
      3'd1:    v = 10'd500;
      3'd2:    v = 10'd200;
      3'd3:    v = 10'd100;
      3'd4:    v = 10'd50;
      3'd5:    v = 10'd25;
      3'd6:    v = 10'd10;
      default: v = 10'd5;
    endcase
    return v;
  endfunction

  function automatic logic [CntW-1:0] stock_init(input logic [1:0] idx);
    logic [CntW-1:0] v;
    case (idx)
      2'd0:    v = 8'd10;
      2'd1:    v = 8'd20;
      2'd2:    v = 8'd30;
      default: v = 8'd25;
    endcase
    return v;
  endfunction

  function automatic logic [CntW-1:0] box_init(input logic [2:0] slot);
    logic [CntW-1:0] v;
    case (slot)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd10;
      3'd2:    v = 8'd20;
      3'd3:    v = 8'd43;
      3'd4:    v = 8'd48;
      3'd5:    v = 8'd80;
      default: v = 8'd1;
    endcase
    return v;
  endfunction

  function automatic logic [PriceW-1:0] price_init(input logic [1:0] idx);
    logic [PriceW-1:0] v;
    case (idx)
      2'd0:    v = 12'd250;
      2'd1:    v = 12'd120;
      2'd2:    v = 12'd320;
      default: v = 12'd240;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/vcc_div.sv
// ----------------------------------------------------------------------------
// vcc_div
// Shared restoring divider: one compare-subtract per cycle, quotient
// saturated to the count width.
// ----------------------------------------------------------------------------
`default_nettype none

module vcc_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [vcc_pkg::BalW-1:0]   dividend,
  input  wire logic [vcc_pkg::MoneyW-1:0] divisor,
  output vcc_pkg::vcc_div_st_t            st
);
  import vcc_pkg::*;

  logic              busy;
  logic              done;
  logic [BalW-1:0]   rem;
  logic [MoneyW-1:0] dsr;
  logic [ShiftW-1:0] pos;
  logic [CntW-1:0]   quot;
  logic [ProdW-1:0]  trial;
  logic              ge;
  logic              step_end;

  // Divisor shifted to the current quotient bit
  assign trial = {{(ProdW-MoneyW){1'b0}}, dsr} << pos;
  assign ge    = {{(ProdW-BalW){1'b0}}, rem} >= trial;

  // Overflow found on the first step, or the last quotient bit resolved
  assign step_end = busy && ((pos == ShiftW'(CntW) && ge) || pos == '0);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= step_end && !start;
      if (start) begin
        busy <= 1'b1;
      end else if (step_end) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath; first step tests for overflow past the count width
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsr  <= divisor;
      pos  <= ShiftW'(CntW);
      quot <= '0;
    end else if (busy) begin
      if (pos == ShiftW'(CntW)) begin
        if (ge) quot <= '1;
        pos <= pos - 1'b1;
      end else begin
        if (ge) rem <= rem - trial[BalW-1:0];
        quot[pos[2:0]] <= ge;
        if (pos != '0) pos <= pos - 1'b1;
      end
    end
  end

  assign st.busy = busy;
  assign st.done = done;
  assign st.quot = quot;

endmodule

`default_nettype wire

### rtl/core/vending_change_controller_unit.sv
// Insert, select, load and unknown commands give a registered result; the
//   next command can be taken while that result is shown, if not stalled.
// Change: each skipped slot takes a scan step, and each slot paid out goes
//   through scan, up to 9 divider steps and its done, multiply, subtract and
//   emit; emit waits while results are stalled. One command at a time.
// Synchronous reset restores prices, stock, coin box and clears balance.
// ----------------------------------------------------------------------------
// vending_change_controller_unit
// Vending controller with balance, stock, coin box and greedy change.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vending_change_controller_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [vcc_pkg::PriceW-1:0] cfg_data,
  input  wire logic                       cmd_valid,
  output logic                            cmd_stall,
  input  wire vcc_pkg::vcc_in_t           cmd_item,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output vcc_pkg::vcc_out_t               res_item
);
  import vcc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SUB   = 3'd4;
  localparam logic [2:0] S_COIN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state;
  logic [PriceW-1:0] price   [NumPrices];
  logic [CntW-1:0]   stock   [NumProducts];
  logic [CntW-1:0]   box     [NumDenoms];
  logic [BalW-1:0]   balance;        // amount owed while paying change
  logic [2:0]        slot;
  logic [CntW-1:0]   ncoins;
  logic [ProdW-1:0]  paid;

  logic              out_free;
  logic              accept;
  logic              div_start;
  vcc_div_st_t       div_st;
  logic [MoneyW-1:0] cur_val;
  logic [CntW-1:0]   cur_box;
  logic              skip;
  logic              money_ok;
  logic [BalW:0]     bal_sum;
  logic [CntW-1:0]   sel_stock;
  logic [PriceW-1:0] sel_price;
  vcc_out_t          res_item_next;

  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = (state != S_IDLE) || !out_free;
  assign accept    = cmd_valid && !cmd_stall;

  assign cur_val   = denom_val(slot);
  assign cur_box   = box[slot];
  assign skip      = (cur_box == '0) || (balance < {{(BalW-MoneyW){1'b0}}, cur_val});
  assign div_start = (state == S_SCAN) && !skip;

  assign sel_stock = stock[cmd_item.product_index];
  assign sel_price = price[cmd_item.product_index];
  assign bal_sum   = {1'b0, balance} + {{(BalW+1-MoneyW){1'b0}}, cmd_item.money_value};

  // Insert accepts only exact denomination values
  always_comb begin
    money_ok = 1'b0;
    for (int i = 0; i < NumDenoms; i++) begin
      if (cmd_item.money_value == denom_val(3'(i))) money_ok = 1'b1;
    end
  end

  // Shared divider: owed / coin value
  vcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (balance),
    .divisor  (cur_val),
    .st       (div_st)
  );

  // Price registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumPrices; i++) price[i] <= price_init(2'(i));
    end else if (cfg_we) begin
      price[cfg_index] <= cfg_data;
    end
  end

  // Sequencer, balance, stock and coin box
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      balance <= '0;
      slot    <= '0;
      for (int i = 0; i < NumProducts; i++) stock[i] <= stock_init(2'(i));
      for (int i = 0; i < NumDenoms; i++) box[i] <= box_init(3'(i));
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd_item.cmd)
              CMD_INSERT: begin
                if (money_ok) balance <= bal_sum[BalW] ? '1 : bal_sum[BalW-1:0];
              end
              CMD_SELECT: begin
                if (sel_stock != '0 &&
                    balance >= {{(BalW-PriceW){1'b0}}, sel_price}) begin
                  stock[cmd_item.product_index] <= sel_stock - 1'b1;
                  balance <= balance - {{(BalW-PriceW){1'b0}}, sel_price};
                end
              end
              CMD_CHANGE: begin
                slot  <= '0;
                state <= S_SCAN;
              end
              CMD_LOAD_STOCK: stock[cmd_item.product_index] <= cmd_item.load_count;
              CMD_LOAD_COINS: box[cmd_item.denom_index] <= cmd_item.load_count;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (!skip) begin
            state <= S_DIV;
          end else if (slot == 3'(NumDenoms-1)) begin
            state <= S_DONE;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            ncoins <= (div_st.quot < cur_box) ? div_st.quot : cur_box;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          paid  <= {{(ProdW-CntW){1'b0}}, ncoins} * {{(ProdW-MoneyW){1'b0}}, cur_val};
          state <= S_SUB;
        end
        S_SUB: begin
          balance   <= balance - paid[BalW-1:0];
          box[slot] <= cur_box - ncoins;
          state     <= S_COIN;
        end
        S_COIN: begin
          if (out_free) begin
            if (slot == 3'(NumDenoms-1)) begin
              state <= S_DONE;
            end else begin
              slot  <= slot + 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            balance <= '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result of a single-transaction command
  always_comb begin
    res_item_next = '{status: ST_REJECTED, product_out: '0, denomination: '0,
                      coin_count: '0, balance_now: balance, remaining_change: '0,
                      last: 1'b1};
    case (cmd_item.cmd) inside
      CMD_INSERT: begin
        res_item_next.status = money_ok ? ST_ACCEPTED : ST_REJECTED;
        if (money_ok) res_item_next.balance_now = bal_sum[BalW] ? '1 : bal_sum[BalW-1:0];
      end
      CMD_SELECT: begin
        res_item_next.product_out = cmd_item.product_index;
        if (sel_stock == '0) begin
          res_item_next.status = ST_NO_STOCK;
        end else if (balance < {{(BalW-PriceW){1'b0}}, sel_price}) begin
          res_item_next.status = ST_SHORT_FUNDS;
        end else begin
          res_item_next.status      = ST_VENDED;
          res_item_next.balance_now = balance - {{(BalW-PriceW){1'b0}}, sel_price};
        end
      end
      CMD_LOAD_STOCK, CMD_LOAD_COINS: res_item_next.status = ST_LOADED;
      default: ;
    endcase
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && cmd_item.cmd != CMD_CHANGE) begin
      res_valid <= 1'b1;
    end else if ((state == S_COIN || state == S_DONE) && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept && cmd_item.cmd != CMD_CHANGE) begin
      res_item <= res_item_next;
    end else if (state == S_COIN && out_free) begin
      res_item <= '{status: ST_COINS_OUT, product_out: '0, denomination: cur_val,
                    coin_count: ncoins, balance_now: balance,
                    remaining_change: balance, last: 1'b0};
    end else if (state == S_DONE && out_free) begin
      res_item <= '{status: ST_CHANGE_DONE, product_out: '0, denomination: '0,
                    coin_count: '0, balance_now: '0, remaining_change: balance,
                    last: 1'b1};
    end
  end

  // Checks
  `ASSERT_RST(a_accept_idle, clk, rst, accept |-> state == S_IDLE)
  `ASSERT_RST(a_div_done_in_div, clk, rst, div_st.done |-> state == S_DIV)
  `ASSERT_RST(a_div_busy_in_div, clk, rst, div_st.busy |-> state == S_DIV)
  `ASSERT_RST(a_coin_nonzero, clk, rst,
              (res_valid && res_item.status == ST_COINS_OUT) |-> res_item.coin_count != '0)
  `ASSERT_RST(a_change_clears, clk, rst,
              (state == S_DONE && out_free) |=> (balance == '0 && state == S_IDLE))

endmodule

`default_nettype wire
